// File: sv/program_image_loader_with_section_read_unit_defines.svh
// Assertion macros for the program image loader.
`ifndef PROGRAM_IMAGE_LOADER_WITH_SECTION_READ_UNIT_DEFINES_SVH
`define PROGRAM_IMAGE_LOADER_WITH_SECTION_READ_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PIL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PIL_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PIL_ASSERT(label, prop, msg)
`define PIL_NEVER(label, expr, msg)
`endif
`endif

// File: sv/pil_pkg.sv
// ----------------------------------------------------------------------------
// pil_pkg
// Shared types and codes of the program image loader.
// ----------------------------------------------------------------------------
package pil_pkg;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  image_byte;
    logic [31:0] address;
  } item_t;
endpackage

// File: sv/pil_front.sv
// ----------------------------------------------------------------------------
// pil_front
// Input side: takes transfers into a short queue toward the execution unit.
// ----------------------------------------------------------------------------
`include "program_image_loader_with_section_read_unit_defines.svh"
module pil_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_opcode,
  input  logic [7:0]     in_image_byte,
  input  logic [31:0]    in_address,
  output logic           q_valid,
  output pil_pkg::item_t q_item,
  input  logic           q_pop
);
  pil_pkg::item_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push;

  assign in_stall = cnt_r[1];
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{in_opcode, in_image_byte, in_address};
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  `PIL_NEVER(a_no_pop_empty, q_pop && !q_valid, "pop from empty queue")
  `PIL_NEVER(a_cnt_range, cnt_r == 2'd3, "queue count overflow")
  `PIL_ASSERT(a_full_stall, cnt_r == 2'd2 |-> in_stall, "full queue not stalling")
endmodule

// File: sv/pil_back.sv
// ----------------------------------------------------------------------------
// pil_back
// Execution unit: parses the image, stores data and answers reads.
// ----------------------------------------------------------------------------
`include "program_image_loader_with_section_read_unit_defines.svh"
module pil_back #(
  parameter int MAX_SECTIONS = 16,
  parameter int DATA_BYTES   = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     bss_code,
  input  logic           q_valid,
  input  pil_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_read_data,
  output logic           out_hit,
  output logic           out_load_done,
  output logic           out_load_error
);
  localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CW = $clog2(MAX_SECTIONS + 1);
  localparam int AW = $clog2(DATA_BYTES);
  localparam int FW = AW + 1;
  localparam logic [31:0] MAXS = 32'(MAX_SECTIONS);
  localparam logic [32:0] DB   = 33'(DATA_BYTES);

  typedef enum logic [2:0] {PH_HEADER, PH_SECTIONS, PH_SYMBOLS, PH_DATA,
                            PH_DONE, PH_ERROR, PH_ADV} phase_t;
  typedef enum logic [2:0] {S_IDLE, S_ADV, S_SCAN, S_RD, S_OUT} st_t;

  logic [31:0]   base_m [MAX_SECTIONS];
  logic [31:0]   len_m  [MAX_SECTIONS];
  logic          bss_m  [MAX_SECTIONS];
  logic [FW-1:0] start_m[MAX_SECTIONS];
  logic [7:0]    store  [DATA_BYTES];

  st_t st_r;
  phase_t ph_r;
  logic [5:0] pos_r;
  logic [31:0] fa_r, nsec_r, syms_r, left_r;
  logic [CW-1:0] cur_r;
  logic [FW-1:0] fill_r;
  logic lh_v_r;
  logic [SW-1:0] lh_i_r, scan_r;
  logic [31:0] addr_r;
  logic hit_r, bssrd_r, probe_r;
  logic [7:0] rd_r;
  logic [CW-1:0] n_lim;
  logic [7:0] b;
  logic [31:0] fa_n, off;
  logic [SW-1:0] ci;
  logic [FW-1:0] idx;

  assign n_lim = (nsec_r > MAXS) ? CW'(MAX_SECTIONS) : nsec_r[CW-1:0];
  assign b = q_item.image_byte;
  assign fa_n = fa_r | ({24'd0, b} << {pos_r[1:0], 3'd0});
  assign ci = cur_r[SW-1:0];
  assign q_pop = q_valid && st_r == S_IDLE && !(out_valid && out_stall);

  function automatic logic covers(logic [31:0] a, logic [31:0] bs, logic [31:0] ln);
    return a >= bs && (a - bs) < ln;
  endfunction

  always_ff @(posedge clk) begin
    if (st_r == S_RD) rd_r <= store[idx[AW-1:0]];
    if (ph_r == PH_DATA && q_pop && q_item.opcode == pil_pkg::OP_LOAD
        && fill_r < FW'(DATA_BYTES))
      store[fill_r[AW-1:0]] <= b;
  end

  always_comb begin
    off = addr_r - base_m[scan_r];
    idx = start_m[scan_r] + off[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= PH_HEADER; pos_r <= '0; fa_r <= '0; nsec_r <= '0;
      syms_r <= '0; left_r <= '0; cur_r <= '0; fill_r <= '0; lh_v_r <= 1'b0;
      lh_i_r <= '0; out_valid <= 1'b0; scan_r <= '0;
    end else begin
      if (out_valid && !out_stall && st_r != S_OUT) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_pop) begin
          hit_r <= 1'b0; bssrd_r <= 1'b0; addr_r <= q_item.address;
          st_r <= S_OUT;
          unique case (q_item.opcode)
            pil_pkg::OP_CLEAR: begin
              ph_r <= PH_HEADER; pos_r <= '0; fa_r <= '0; nsec_r <= '0; syms_r <= '0;
              cur_r <= '0; left_r <= '0; fill_r <= '0; lh_v_r <= 1'b0; lh_i_r <= '0;
            end
            pil_pkg::OP_LOAD: begin
              lh_v_r <= 1'b0;
              unique case (ph_r)
                PH_HEADER: begin
                  fa_r <= fa_n; pos_r <= pos_r + 6'd1;
                  if (pos_r[1:0] == 2'd3) begin
                    fa_r <= '0;
                    if (pos_r[5:2] == 4'd5) nsec_r <= fa_n;
                    if (pos_r[5:2] == 4'd7) syms_r <= fa_n;
                  end
                  if (pos_r == 6'd35) begin
                    pos_r <= '0; cur_r <= '0;
                    if (nsec_r > MAXS) ph_r <= PH_ERROR;
                    else if (nsec_r != 0) ph_r <= PH_SECTIONS;
                    else if (syms_r != 0) ph_r <= PH_SYMBOLS;
                    else begin fill_r <= '0; ph_r <= PH_ADV; st_r <= S_ADV; end
                  end
                end
                PH_SECTIONS: begin
                  if (pos_r == 6'd0) bss_m[ci] <= (b == bss_code);
                  if (pos_r >= 6'd4 && pos_r < 6'd12) begin
                    fa_r <= fa_n;
                    if (pos_r[1:0] == 2'd3) begin
                      fa_r <= '0;
                      if (pos_r < 6'd8) base_m[ci] <= fa_n; else len_m[ci] <= fa_n;
                    end
                  end
                  pos_r <= pos_r + 6'd1;
                  if (pos_r == 6'd15) begin
                    pos_r <= '0; cur_r <= cur_r + CW'(1);
                    if (32'(cur_r) + 32'd1 >= nsec_r) begin
                      if (syms_r != 0) ph_r <= PH_SYMBOLS;
                      else begin
                        cur_r <= '0; fill_r <= '0; ph_r <= PH_ADV; st_r <= S_ADV;
                      end
                    end
                  end
                end
                PH_SYMBOLS: begin
                  pos_r <= pos_r + 6'd1;
                  if (pos_r == 6'd7) begin
                    pos_r <= '0; syms_r <= syms_r - 32'd1;
                    if (syms_r == 32'd1) begin
                      cur_r <= '0; fill_r <= '0; ph_r <= PH_ADV; st_r <= S_ADV;
                    end
                  end
                end
                PH_DATA: begin
                  fill_r <= fill_r + FW'(1); left_r <= left_r - 32'd1;
                  if (left_r == 32'd1) begin
                    cur_r <= cur_r + CW'(1); ph_r <= PH_ADV; st_r <= S_ADV;
                  end
                end
                default: ;
              endcase
            end
            pil_pkg::OP_READ: if (ph_r == PH_DONE && n_lim != 0) begin
              if (lh_v_r && CW'(lh_i_r) < n_lim) begin
                scan_r <= lh_i_r; probe_r <= 1'b1;
              end else begin
                scan_r <= '0; probe_r <= 1'b0;
              end
              st_r <= S_SCAN;
            end
            default: ;
          endcase
        end
        S_ADV: begin
          // One table entry per cycle while hunting for the next stored section.
          if (32'(cur_r) < nsec_r && cur_r < CW'(MAX_SECTIONS)) begin
            start_m[ci] <= fill_r;
            if (bss_m[ci] || len_m[ci] == 0) cur_r <= cur_r + CW'(1);
            else begin
              st_r <= S_OUT;
              if (33'(len_m[ci]) > DB - 33'(fill_r)) ph_r <= PH_ERROR;
              else begin left_r <= len_m[ci]; ph_r <= PH_DATA; end
            end
          end else begin ph_r <= PH_DONE; st_r <= S_OUT; end
        end
        S_SCAN: begin
          if (covers(addr_r, base_m[scan_r], len_m[scan_r])) begin
            lh_v_r <= 1'b1; lh_i_r <= scan_r; hit_r <= 1'b1;
            bssrd_r <= bss_m[scan_r] || idx >= FW'(DATA_BYTES);
            st_r <= S_RD;
          end else if (probe_r) begin
            // The last-hit section missed, so the table is scanned in order.
            probe_r <= 1'b0; scan_r <= '0;
          end else if (CW'(scan_r) + CW'(1) >= n_lim) st_r <= S_OUT;
          else scan_r <= scan_r + SW'(1);
        end
        S_RD: st_r <= S_OUT;
        S_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1; st_r <= S_IDLE;
          out_read_data <= (hit_r && !bssrd_r) ? rd_r : 8'd0;
          out_hit <= hit_r;
          out_load_done <= ph_r == PH_DONE;
          out_load_error <= ph_r == PH_ERROR;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `PIL_NEVER(a_adv_phase, st_r == S_ADV && ph_r != PH_ADV, "advance outside advance phase")
  `PIL_NEVER(a_fill_max, fill_r > FW'(DATA_BYTES), "store fill past capacity")
  `PIL_ASSERT(a_pop_idle, q_pop |-> st_r == S_IDLE, "pop while busy")
endmodule

// File: sv/program_image_loader_with_section_read_unit.sv
// A read checks the section table entry by entry, first the last-hit section if
// one is held, up to MAX_SECTIONS+1 entries in all when the last-hit section misses.
// A byte that ends a table or a section's data walks the entries to the next
// stored section. The unit takes one item at a time, a new one only once the
// last result has been handed out.
// Reset (synchronous, rst_n low) clears parse state, queue, last hit and register.
// ----------------------------------------------------------------------------
// program_image_loader_with_section_read_unit
// Top level: configuration register, input queue and execution unit.
// ----------------------------------------------------------------------------
module program_image_loader_with_section_read_unit #(
  parameter int MAX_SECTIONS = 16,
  parameter int DATA_BYTES   = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_image_byte,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_hit,
  output logic        out_load_done,
  output logic        out_load_error,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [7:0] bss_r;
  logic q_valid, q_pop;
  pil_pkg::item_t q_item;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {24'd0, bss_r};

  always_ff @(posedge clk) begin
    if (!rst_n) bss_r <= '0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr) bss_r <= cfg_pwdata[7:0];
  end

  pil_front u_front (.clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_image_byte,
    .in_address, .q_valid, .q_item, .q_pop);

  pil_back #(.MAX_SECTIONS(MAX_SECTIONS), .DATA_BYTES(DATA_BYTES)) u_back (
    .clk, .rst_n, .bss_code(bss_r), .q_valid, .q_item, .q_pop, .out_valid, .out_stall,
    .out_read_data, .out_hit, .out_load_done, .out_load_error);
endmodule

// File: sim/program_image_loader_with_section_read_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// program_image_loader_with_section_read_unit_test
// Self-checking bench: builds program images with random section tables,
// loads them byte by byte, reads back through the section lookup and checks
// every result against a cycle-free model of the loader or, for directed rows, their own values.
// ----------------------------------------------------------------------------
module program_image_loader_with_section_read_unit_test;
  localparam int NSEC  = 16;
  localparam int STORE = 65536;
  localparam int LIMIT = 600000;

  typedef enum logic [2:0] {
    PH_HEADER, PH_SECTIONS, PH_SYMBOLS, PH_DATA, PH_DONE, PH_ERROR
  } phase_e;

  typedef struct {
    logic [1:0]  opcode;
    logic [7:0]  image_byte;
    logic [31:0] address;
    bit          typed;
    logic [7:0]  rd;
    logic        hit, done, err;
  } stim_t;

  typedef struct {
    logic [7:0] rd;
    logic       hit, done, err;
  } reply_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [1:0]  in_opcode;
  logic [7:0]  in_image_byte;
  logic [31:0] in_address;
  logic        out_valid, out_stall;
  logic [7:0]  out_read_data;
  logic        out_hit, out_load_done, out_load_error;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  program_image_loader_with_section_read_unit u_top (.*);

  // Loader model state.
  logic [7:0]  bss_code;
  phase_e      phase;
  int unsigned rec_pos, field_acc, sec_count, sym_left, sec_idx, bytes_left, fill;
  int unsigned sec_base [NSEC];
  int unsigned sec_len  [NSEC];
  bit          sec_bss  [NSEC];
  int unsigned sec_start[NSEC];
  logic [7:0]  image_mem[STORE];
  bit          last_ok;
  int unsigned last_idx;

  stim_t  stim_q[$];
  reply_t reply_q[$];
  int     errors = 0, mismatches = 0, cycles = 0, sent = 0, max_gap = 5;
  int     stall_left = 0;
  logic   long_hold;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic void model_clear();
    phase = PH_HEADER; rec_pos = 0; field_acc = 0; sec_count = 0; sym_left = 0;
    sec_idx = 0; bytes_left = 0; fill = 0; last_ok = 1'b0; last_idx = 0;
  endfunction

  // Walk to the next section that holds stored data.
  function automatic void next_data_section();
    while (sec_idx < sec_count && sec_idx < NSEC) begin
      sec_start[sec_idx] = fill;
      if (sec_bss[sec_idx] || sec_len[sec_idx] == 0) begin
        sec_idx++;
        continue;
      end
      if (sec_len[sec_idx] > STORE - fill) begin
        phase = PH_ERROR;
        return;
      end
      bytes_left = sec_len[sec_idx];
      phase = PH_DATA;
      return;
    end
    phase = PH_DONE;
  endfunction

  function automatic void start_data();
    sec_idx = 0; fill = 0;
    next_data_section();
  endfunction

  function automatic void tables_done();
    rec_pos = 0;
    if (sym_left != 0) phase = PH_SYMBOLS;
    else start_data();
  endfunction

  function automatic void take_image_byte(logic [7:0] b);
    int unsigned p;
    p = rec_pos;
    case (phase)
      PH_HEADER: begin
        field_acc |= int'(b) << (8 * (p % 4));
        if (p % 4 == 3) begin
          if (p / 4 == 5) sec_count = field_acc;
          if (p / 4 == 7) sym_left = field_acc;
          field_acc = 0;
        end
        rec_pos = p + 1;
        if (p == 35) begin
          rec_pos = 0; sec_idx = 0;
          if (sec_count > NSEC) phase = PH_ERROR;
          else if (sec_count != 0) phase = PH_SECTIONS;
          else tables_done();
        end
      end
      PH_SECTIONS: begin
        if (sec_idx >= NSEC) begin
          phase = PH_ERROR;
        end else begin
          if (p == 0) sec_bss[sec_idx] = (b == bss_code);
          if (p >= 4 && p < 12) begin
            field_acc |= int'(b) << (8 * (p % 4));
            if (p % 4 == 3) begin
              if (p < 8) sec_base[sec_idx] = field_acc;
              else sec_len[sec_idx] = field_acc;
              field_acc = 0;
            end
          end
          rec_pos = p + 1;
          if (p == 15) begin
            rec_pos = 0;
            sec_idx++;
            if (sec_idx >= sec_count) tables_done();
          end
        end
      end
      PH_SYMBOLS: begin
        rec_pos = p + 1;
        if (p == 7) begin
          rec_pos = 0;
          sym_left--;
          if (sym_left == 0) start_data();
        end
      end
      PH_DATA: begin
        if (fill < STORE) image_mem[fill] = b;
        fill++;
        bytes_left--;
        if (bytes_left == 0) begin
          sec_idx++;
          next_data_section();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit covers(int unsigned i, logic [31:0] a);
    return a >= sec_base[i] && (a - sec_base[i]) < sec_len[i];
  endfunction

  function automatic logic [7:0] byte_at(int unsigned i, logic [31:0] a);
    int unsigned idx;
    if (sec_bss[i]) return 8'd0;
    idx = sec_start[i] + (a - sec_base[i]);
    if (idx >= STORE) return 8'd0;
    return image_mem[idx];
  endfunction

  function automatic reply_t loader_reply(stim_t s);
    reply_t r;
    int unsigned n;
    r.rd = 8'd0; r.hit = 1'b0;
    if (s.opcode == pil_pkg::OP_CLEAR) begin
      model_clear();
    end else if (s.opcode == pil_pkg::OP_LOAD) begin
      last_ok = 1'b0;
      take_image_byte(s.image_byte);
    end else if (s.opcode == pil_pkg::OP_READ && phase == PH_DONE) begin
      n = (sec_count > NSEC) ? NSEC : sec_count;
      if (last_ok && last_idx < n && covers(last_idx, s.address)) begin
        r.hit = 1'b1;
        r.rd = byte_at(last_idx, s.address);
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          if (covers(i, s.address)) begin
            last_ok = 1'b1; last_idx = i;
            r.hit = 1'b1;
            r.rd = byte_at(i, s.address);
            break;
          end
        end
      end
    end
    r.done = (phase == PH_DONE);
    r.err = (phase == PH_ERROR);
    return r;
  endfunction

  function automatic void add(logic [1:0] op, logic [31:0] b, logic [31:0] a);
    stim_t s;
    s = '{opcode: op, image_byte: b[7:0], address: a, typed: 1'b0, rd: 8'd0,
          hit: 1'b0, done: 1'b0, err: 1'b0};
    stim_q = {stim_q, s};
  endfunction

  function automatic void add_dword(int unsigned v);
    for (int k = 0; k < 4; k++) add(pil_pkg::OP_LOAD, v >> (8 * k), $urandom);
  endfunction

  // One image: clear, header, section table, symbols, data, then reads and stray loads.
  function automatic void build_image();
    int unsigned n, nsym, r, fill_sz, lim;
    int unsigned bases[NSEC], lens[NSEC];
    bit          zf[NSEC];
    r = $urandom_range(0, 9);
    if (r == 0) n = 0;
    else if (r == 1) n = ($urandom_range(0, 1) != 0) ? 17 : ($urandom | 32'h8000_0000);
    else if (r == 2) n = NSEC;
    else n = $urandom_range(1, 4);
    nsym = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
    add(pil_pkg::OP_CLEAR, $urandom, $urandom);
    for (int k = 3; k >= 0; k--) add(pil_pkg::OP_LOAD, $urandom, $urandom); // magic
    for (int d = 1; d < 9; d++) begin
      if (d == 5) add_dword(n);
      else if (d == 7) add_dword(nsym);
      else add_dword($urandom);
    end
    lim = (n > NSEC) ? 0 : n;
    for (int i = 0; i < lim; i++) begin
      zf[i] = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) lens[i] = 0;
      else if (r == 1) lens[i] = ($urandom_range(0, 1) != 0) ? 32'h0001_0001 : 32'hFFFF_FFFF;
      else lens[i] = $urandom_range(1, (n == NSEC) ? 6 : 20);
      if (zf[i] && $urandom_range(0, 1)) lens[i] = $urandom;
      r = $urandom_range(0, 7);
      if (r == 0) bases[i] = 32'hFFFF_FFFF - $urandom_range(0, 8);
      else if (r == 1) bases[i] = 0;
      else if (r == 2 && i > 0) bases[i] = bases[i - 1] + $urandom_range(0, 3);
      else bases[i] = $urandom;
      add(pil_pkg::OP_LOAD,
          zf[i] ? {24'd0, bss_code} : ($urandom | 32'h1) ^ {24'd0, bss_code}, $urandom);
      for (int k = 1; k < 4; k++) add(pil_pkg::OP_LOAD, $urandom, $urandom);
      add_dword(bases[i]);
      add_dword(lens[i]);
      add_dword($urandom);
    end
    for (int k = 0; k < 8 * nsym; k++) add(pil_pkg::OP_LOAD, $urandom, $urandom);
    fill_sz = 0;
    for (int i = 0; i < lim; i++) begin
      if (zf[i] || lens[i] == 0) continue;
      if (lens[i] > STORE - fill_sz) begin
        for (int k = 0; k < 3; k++) add(pil_pkg::OP_LOAD, $urandom, $urandom);
        break;
      end
      for (int k = 0; k < lens[i]; k++) add(pil_pkg::OP_LOAD, $urandom, $urandom);
      fill_sz += lens[i];
    end
    for (int q = 0; q < 14; q++) begin
      r = $urandom_range(0, 9);
      if (r == 0 || lim == 0) begin
        add(pil_pkg::OP_READ, $urandom, $urandom);
      end else if (r == 1) begin
        add(pil_pkg::OP_LOAD, $urandom, $urandom); // ignored once done, drops the last hit
      end else begin
        n = $urandom_range(0, lim - 1);
        add(pil_pkg::OP_READ, $urandom,
            bases[n] + ((lens[n] > 64) ? $urandom_range(0, 63)
                                       : $urandom_range(0, lens[n])));
      end
    end
  endfunction

  function automatic void add_noise();
    int unsigned k;
    k = $urandom_range(1, 3);
    for (int i = 0; i < k; i++) add(2'($urandom_range(0, 3)), $urandom, $urandom);
  endfunction

  task automatic cfg_write(logic [7:0] v);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= 1'b0; cfg_pwdata <= {24'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    bss_code = v;
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (reply_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_all();
    stim_t  s;
    reply_t r;
    int     gap;
    while (stim_q.size() != 0) begin
      s = stim_q.pop_front();
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_opcode <= s.opcode; in_image_byte <= s.image_byte; in_address <= s.address;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      r = loader_reply(s);
      if (s.typed) r = '{rd: s.rd, hit: s.hit, done: s.done, err: s.err};
      reply_q = {reply_q, r};
      sent++;
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: random hold-off after each transfer, plus one long hold.
  always @(posedge clk) begin
    if (out_valid && !out_stall) stall_left = $urandom_range(0, max_gap);
    else if (stall_left > 0) stall_left--;
    out_stall <= long_hold || (stall_left != 0);
  end

  initial begin
    long_hold = 1'b0;
    wait (sent >= 300);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        errors++;
        $display("unexpected result rd=%h hit=%b", out_read_data, out_hit);
      end else begin
        e = reply_q.pop_front();
        if (out_read_data !== e.rd || out_hit !== e.hit ||
            out_load_done !== e.done || out_load_error !== e.err) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rd=%h hit=%b done=%b err=%b got rd=%h hit=%b done=%b err=%b",
                     e.rd, e.hit, e.done, e.err,
                     out_read_data, out_hit, out_load_done, out_load_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Directed rows: opcode, byte, address, typed, read_data, hit, done, error.
  stim_t directed[] = '{
    '{pil_pkg::OP_READ,  8'h00, 32'h0000_0000, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{pil_pkg::OP_READ,  8'hFF, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{pil_pkg::OP_NONE,  8'hFF, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{pil_pkg::OP_NONE,  8'h00, 32'h0000_0000, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{pil_pkg::OP_LOAD,  8'hFF, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{pil_pkg::OP_LOAD,  8'h00, 32'h0000_0000, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{pil_pkg::OP_READ,  8'h5A, 32'h8000_0000, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{pil_pkg::OP_CLEAR, 8'hFF, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{pil_pkg::OP_CLEAR, 8'h00, 32'h0000_0000, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{pil_pkg::OP_READ,  8'hA5, 32'h7FFF_FFFF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}
  };

  initial begin
    logic [7:0] codes[4];
    rst_n = 1'b0; in_valid = 1'b0; in_opcode = '0; in_image_byte = '0; in_address = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = 1'b0; cfg_pwdata = '0;
    bss_code = 8'd0;
    for (int i = 0; i < NSEC; i++) begin
      sec_base[i] = 0; sec_len[i] = 0; sec_bss[i] = 1'b0; sec_start[i] = 0;
    end
    model_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) stim_q = {stim_q, directed[i]};
    send_all();
    drain();
    codes = '{8'hFF, 8'h00, 8'h00, 8'h00};
    codes[2] = 8'($urandom);
    codes[3] = 8'($urandom);
    for (int p = 0; p < 4; p++) begin
      cfg_write(codes[p]);
      max_gap = (p == 2) ? 0 : 5; // one phase runs back to back
      while (stim_q.size() < 320) begin
        if ($urandom_range(0, 9) == 0) add_noise();
        build_image();
      end
      send_all();
      drain();
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
